// ===== rtl/core/rrf_pkg.sv =====
// Package for the RGB frame rotation engine: operation codes, register
// indexes, rotation mode codes and fixed field widths.
// No dependencies.
package rrf_pkg;

  localparam int PIXEL_W = 24;  // one RGB pixel, three bytes
  localparam int DIM_W   = 7;   // width of the frame size registers
  localparam int CFG_IDX_W = 2; // register index on the configuration port

  // Operation carried by an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;

  // Rotation modes.
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_270  = 2'd3;

  // Reset value of both frame size registers.
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

endpackage

// ===== rtl/core/rotate_rgb_frame.sv =====
// Top level of the RGB frame rotation engine: frame store, load and fetch
// position counters, fetch address generation and the output register.
// Depends on rrf_pkg.

// The engine takes one item per clock. A load item writes its pixel into the
// frame store at the next source position in raster order; a fetch item reads
// the next pixel of the frame rotated by 0, 90, 180 or 270 degrees clockwise
// and returns it with a flag on the last pixel of the rotated frame. Loads
// produce no result. The accepting edge of a fetch item does the registered
// read of the frame store, and the output register takes the result from the
// read stage as soon as it can advance. The store has one write port and
// one read port, and each item uses exactly one of them, so with the output
// channel free the input never stalls; it stalls only when a fetch result
// waits in the read stage while the output register is held by out_stall_i.
// The frame store is not cleared after reset: a fetch must only touch
// positions that were loaded since reset. The size registers are clamped to
// one at the low end and to MAX_WIDTH and MAX_HEIGHT at the high end, and a
// position counter that a size change leaves outside the frame restarts at
// zero. Configuration is written through a valid and ready port that is
// always ready. Write it only while the engine is idle; the block does not enforce it.
module rotate_rgb_frame
  import rrf_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [PIXEL_W-1:0]   pixel_in_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIXEL_W-1:0]   pixel_out_o,
  output logic                 frame_last_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_CAP = (MAX_DIM > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_DIM;
  localparam int POS_W   = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
  localparam int TOT_W   = 2 * DIM_W;
  localparam int CMP_W   = (ADDR_W + 1 > TOT_W) ? ADDR_W + 1 : TOT_W;
  localparam int WCLAMP  = (MAX_WIDTH > DIM_CAP) ? DIM_CAP : MAX_WIDTH;
  localparam int HCLAMP  = (MAX_HEIGHT > DIM_CAP) ? DIM_CAP : MAX_HEIGHT;

  // Configuration registers.
  logic [1:0]       rot_mode_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;

  // Position counters.
  logic [ADDR_W-1:0] load_idx_q, load_idx_d;
  logic [POS_W-1:0]  major_q, major_d;
  logic [POS_W-1:0]  minor_q, minor_d;

  // Frame store and its registered read port.
  logic [PIXEL_W-1:0] frame_store_q [DEPTH];
  logic [PIXEL_W-1:0] rd_data_q;

  // Read stage and output register.
  logic               s1_valid_q;
  logic               s1_last_q;
  logic               out_valid_q;
  logic [PIXEL_W-1:0] pixel_out_q;
  logic               frame_last_q;

  logic in_accept, load_accept, fetch_accept, out_advance;

  // Effective frame size after clamping.
  logic [DIM_W-1:0] w_eff, h_eff, rows, cols;
  logic [TOT_W-1:0] total;

  // Current and next positions.
  logic [ADDR_W-1:0] load_cur;
  logic [CMP_W-1:0]  load_inc;
  logic [DIM_W-1:0]  maj, mnr, maj_inc, mnr_inc;
  logic [DIM_W-1:0]  src_x, src_y;
  logic [TOT_W-1:0]  fetch_addr;
  logic              fetch_last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_mode_q <= ROT_NONE;
      width_q    <= DIM_RESET;
      height_q   <= DIM_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROTATION_MODE: rot_mode_q <= cfg_data_i[1:0];
        REG_FRAME_WIDTH:   width_q    <= cfg_data_i;
        REG_FRAME_HEIGHT:  height_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero size acts as one, a size above the store's limit as that limit.
  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_q > DIM_W'(WCLAMP)) begin
      w_eff = DIM_W'(WCLAMP);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > DIM_W'(HCLAMP)) begin
      h_eff = DIM_W'(HCLAMP);
    end else begin
      h_eff = height_q;
    end
  end

  assign total = TOT_W'(w_eff) * TOT_W'(h_eff);

  // Quarter turns swap the output frame's rows and columns.
  assign rows = rot_mode_q[0] ? w_eff : h_eff;
  assign cols = rot_mode_q[0] ? h_eff : w_eff;

  // Handshake. The input stalls only when a fetch result sits in the read
  // stage and the output register cannot take it.
  assign out_advance  = !out_valid_q || !out_stall_i;
  assign in_stall_o   = s1_valid_q && !out_advance;
  assign in_accept    = in_valid_i && !in_stall_o;
  assign load_accept  = in_accept && (operation_i == OP_LOAD);
  assign fetch_accept = in_accept && (operation_i == OP_FETCH);

  // Load position: restart if a size change left it outside the frame.
  always_comb begin
    if (CMP_W'(load_idx_q) >= CMP_W'(total)) begin
      load_cur = '0;
    end else begin
      load_cur = load_idx_q;
    end
    load_inc = CMP_W'(load_cur) + CMP_W'(1);
    if (load_inc >= CMP_W'(total)) begin
      load_idx_d = '0;
    end else begin
      load_idx_d = ADDR_W'(load_inc);
    end
  end

  // Fetch position and the source pixel it maps to.
  always_comb begin
    maj = (DIM_W'(major_q) >= rows) ? '0 : DIM_W'(major_q);
    mnr = (DIM_W'(minor_q) >= cols) ? '0 : DIM_W'(minor_q);

    case (rot_mode_q)
      ROT_90: begin
        src_x = maj;
        src_y = h_eff - DIM_W'(1) - mnr;
      end
      ROT_180: begin
        src_x = w_eff - DIM_W'(1) - mnr;
        src_y = h_eff - DIM_W'(1) - maj;
      end
      ROT_270: begin
        src_x = w_eff - DIM_W'(1) - maj;
        src_y = mnr;
      end
      default: begin
        src_x = mnr;
        src_y = maj;
      end
    endcase

    fetch_addr = TOT_W'(src_y) * TOT_W'(w_eff) + TOT_W'(src_x);
    fetch_last = (maj == rows - DIM_W'(1)) && (mnr == cols - DIM_W'(1));

    // Step through the output frame in raster order and wrap at its end.
    maj_inc = maj + DIM_W'(1);
    mnr_inc = mnr + DIM_W'(1);
    if (mnr_inc >= cols) begin
      minor_d = '0;
      major_d = (maj_inc >= rows) ? '0 : POS_W'(maj_inc);
    end else begin
      minor_d = POS_W'(mnr_inc);
      major_d = POS_W'(maj);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
      major_q    <= '0;
      minor_q    <= '0;
    end else begin
      if (load_accept) begin
        load_idx_q <= load_idx_d;
      end
      if (fetch_accept) begin
        major_q <= major_d;
        minor_q <= minor_d;
      end
    end
  end

  // Frame store: one write and one registered read per cycle. Each item
  // uses only one of the two ports, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (load_accept) begin
      frame_store_q[load_cur] <= pixel_in_i;
    end
    if (fetch_accept) begin
      rd_data_q <= frame_store_q[ADDR_W'(fetch_addr)];
    end
  end

  // Read stage control. It only changes when the input side is open.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= fetch_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_accept) begin
      s1_last_q <= fetch_last;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_advance && s1_valid_q) begin
      pixel_out_q  <= rd_data_q;
      frame_last_q <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign frame_last_o = frame_last_q;

`ifndef NO_ASSERTIONS
  // A fetch always reaches the read stage on the next edge.
  a_fetch_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_accept |=> s1_valid_q)
    else $error("fetch item did not reach the read stage");

  // A result in the read stage is never dropped: the output holds one next.
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> out_valid_q)
    else $error("read stage result was lost");

  // The input stalls only when both the read stage and the output are full.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // A load never creates a result in the read stage.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_accept |=> !s1_valid_q)
    else $error("load item produced a result");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the RGB frame rotation engine: a scoreboard class that
// predicts every fetched pixel, plus driver, stall and watchdog processes.
// Depends on rrf_pkg and the rotate_rgb_frame RTL.
import rrf_pkg::*;

typedef struct packed {
  logic [PIXEL_W-1:0] pixel;
  logic               last;
} rotated_pixel_t;

class rotation_scoreboard;
  localparam int DIM_MAX     = 64;
  localparam int STORE_DEPTH = DIM_MAX * DIM_MAX;

  logic [PIXEL_W-1:0] store [STORE_DEPTH];
  bit                 loaded [STORE_DEPTH];
  int unsigned        load_pos;
  int unsigned        out_row;
  int unsigned        out_col;
  logic [1:0]         mode;
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  rotated_pixel_t     rotated_q [$];
  int                 errors;

  function new();
    load_pos   = 0;
    out_row    = 0;
    out_col    = 0;
    mode       = ROT_NONE;
    width_reg  = DIM_RESET;
    height_reg = DIM_RESET;
    errors     = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;
  endfunction

  function int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    case (idx)
      REG_ROTATION_MODE: mode = data[1:0];
      REG_FRAME_WIDTH:   width_reg = data;
      REG_FRAME_HEIGHT:  height_reg = data;
      default: ;
    endcase
  endfunction

  // Shape of the rotated frame: quarter turns swap rows and columns.
  function void output_shape(output int unsigned rows, output int unsigned cols);
    if (mode == ROT_90 || mode == ROT_270) begin
      rows = clamp_dim(width_reg);
      cols = clamp_dim(height_reg);
    end else begin
      rows = clamp_dim(height_reg);
      cols = clamp_dim(width_reg);
    end
  endfunction

  // Store address the next fetch reads. Leaves the counters alone, since a
  // counter outside the frame is only restarted when a fetch really happens.
  function int unsigned fetch_addr();
    int unsigned w, h, rows, cols, row, col, x, y;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    output_shape(rows, cols);
    row = (out_row >= rows) ? 0 : out_row;
    col = (out_col >= cols) ? 0 : out_col;
    case (mode)
      ROT_90: begin
        x = row;
        y = h - 1 - col;
      end
      ROT_180: begin
        x = w - 1 - col;
        y = h - 1 - row;
      end
      ROT_270: begin
        x = w - 1 - row;
        y = col;
      end
      default: begin
        x = col;
        y = row;
      end
    endcase
    return y * w + x;
  endfunction

  function bit fetch_ready();
    return loaded[fetch_addr()];
  endfunction

  function int pending();
    return rotated_q.size();
  endfunction

  function void note_input(logic op, logic [PIXEL_W-1:0] pixel);
    int unsigned total, rows, cols, addr;
    rotated_pixel_t want;
    total = clamp_dim(width_reg) * clamp_dim(height_reg);
    if (op == OP_LOAD) begin
      if (load_pos >= total) load_pos = 0;
      store[load_pos]  = pixel;
      loaded[load_pos] = 1'b1;
      load_pos++;
      if (load_pos >= total) load_pos = 0;
    end else begin
      addr = fetch_addr();
      output_shape(rows, cols);
      if (out_row >= rows) out_row = 0;
      if (out_col >= cols) out_col = 0;
      want.pixel = store[addr];
      want.last  = (out_row == rows - 1) && (out_col == cols - 1);
      rotated_q.push_back(want);
      out_col++;
      if (out_col >= cols) begin
        out_col = 0;
        out_row++;
        if (out_row >= rows) out_row = 0;
      end
    end
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(logic [PIXEL_W-1:0] pixel, logic last);
    rotated_pixel_t want;
    if (rotated_q.size() == 0) begin
      report($sformatf("result with nothing expected, pixel %h last %b", pixel, last));
      return;
    end
    want = rotated_q.pop_front();
    if (pixel !== want.pixel)
      report($sformatf("pixel_out %h, expected %h", pixel, want.pixel));
    if (last !== want.last)
      report($sformatf("frame_last %b, expected %b", last, want.last));
  endtask
endclass

module tb_top;

  // Cycles without any handshake before the run is declared hung. The long
  // receiver hold-off below is the slowest legal stretch, well under this.
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int DRAIN_CYCLES  = 4;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic               operation = OP_LOAD;
  logic [PIXEL_W-1:0] pixel_in = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic [PIXEL_W-1:0] pixel_out_o;
  logic               frame_last_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]   cfg_data = '0;

  rotation_scoreboard sb;

  // Idle percentages for the sender and the receiver, changed per phase.
  int gap_pct   = 0;
  int stall_pct = 0;
  // The driver asks for a long receiver hold-off by bumping hold_asks; the
  // stall process notices the change and counts the hold itself.
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_done = 0;

  always #5 clk_i = ~clk_i;

  // Both size parameters stay at their default of 64, matching the scoreboard.
  rotate_rgb_frame dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation),
    .pixel_in_i   (pixel_in),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // Receiver side. Outside a hold-off the stall is a fresh coin toss every
  // cycle, so stalls land on every phase of the engine's two-stage pipeline.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Every accepted result is compared with the oldest predicted pixel.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall)
      sb.check_result(pixel_out_o, frame_last_o);
  end

  // The watchdog restarts on any handshake and ends a run that stopped moving.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly random pixels, with all-zero and all-one pixels mixed in.
  function automatic logic [PIXEL_W-1:0] next_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  // Frame sizes at the register extremes: zero and values above 64 are
  // clamped by the engine, 1 and 64 are the real limits.
  function automatic logic [DIM_W-1:0] extreme_dim();
    case ($urandom_range(4))
      0:       return '0;
      1:       return DIM_W'(1);
      2:       return DIM_W'(64);
      3:       return '1;
      default: return DIM_W'($urandom_range(65, 126));
    endcase
  endfunction

  // Offer one item and hold it until it is accepted, then note it for
  // prediction and optionally leave the input idle afterwards.
  task automatic send_item(logic op, logic [PIXEL_W-1:0] pixel);
    in_valid  <= 1'b1;
    operation <= op;
    pixel_in  <= pixel;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, pixel);
    items_done++;
    if (gap_pct != 0) begin
      while ($urandom_range(99) < gap_pct) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // Registers change only with the engine empty: no item offered, every
  // predicted pixel delivered, and a pause for the pipeline to settle.
  task automatic program_frame(logic [1:0] rot, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    logic [CFG_IDX_W-1:0] regs [3] = '{REG_ROTATION_MODE, REG_FRAME_WIDTH, REG_FRAME_HEIGHT};
    logic [DIM_W-1:0]     data [3];
    logic [DIM_W-3:0]     spare;
    // The mode register only keeps two bits; now and then the rest of the
    // data word carries junk that must be dropped.
    spare = ($urandom_range(3) == 0) ? (DIM_W-2)'($urandom) : '0;
    data[0] = {spare, rot};
    data[1] = w;
    data[2] = h;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.apply_register(regs[i], data[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mixed loads and fetches. A fetch is only sent when the pixel it reads was
  // loaded since reset; otherwise a load goes out in its place.
  task automatic run_items(int count, int fetch_pct);
    repeat (count) begin
      if ($urandom_range(99) < fetch_pct && sb.fetch_ready())
        send_item(OP_FETCH, next_pixel());
      else
        send_item(OP_LOAD, next_pixel());
    end
  endtask

  task automatic load_frame(int count);
    repeat (count) send_item(OP_LOAD, next_pixel());
  endtask

  initial begin
    int               phase;
    int               total;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. First the reset settings (no rotation, 64 by 64): load
    // one white pixel and read it back.
    send_item(OP_LOAD, '1);
    send_item(OP_FETCH, '0);
    // A 2 by 2 frame with extreme pixel values, read back in every mode.
    // The counters carry over from above, so the frame starts mid-way.
    program_frame(ROT_NONE, DIM_W'(2), DIM_W'(2));
    send_item(OP_LOAD, 24'h000000);
    send_item(OP_LOAD, 24'hFFFFFF);
    send_item(OP_LOAD, 24'h555555);
    send_item(OP_LOAD, 24'hAAAAAA);
    repeat (4) send_item(OP_FETCH, '1);
    program_frame(ROT_90, DIM_W'(2), DIM_W'(2));
    repeat (4) send_item(OP_FETCH, '0);
    program_frame(ROT_180, DIM_W'(2), DIM_W'(2));
    repeat (4) send_item(OP_FETCH, '1);
    program_frame(ROT_270, DIM_W'(2), DIM_W'(2));
    repeat (4) send_item(OP_FETCH, '0);

    // Random part: phases of one register setting each. Most phases load a
    // whole small frame first and then stream fetches over it with reloads
    // in between; a few use the size extremes, and some are mostly loads.
    // The hold-off phase always uses a small, fully loaded frame so that
    // fetches keep coming while the receiver holds off.
    items_done = 0;
    phase = 0;
    while (items_done < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 76;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 76;
        end
        default: begin
          gap_pct   = 34;
          stall_pct = 34;
        end
      endcase
      if (phase == 4 || $urandom_range(99) < 85) begin
        w = DIM_W'($urandom_range(1, 8));
        h = DIM_W'($urandom_range(1, 8));
      end else begin
        w = extreme_dim();
        h = extreme_dim();
      end
      program_frame(2'($urandom_range(3)), w, h);
      total = sb.clamp_dim(w) * sb.clamp_dim(h);

      if (phase == 4) begin
        // Long receiver hold-off while the sender keeps offering fetches:
        // the output and read stages fill and the input must stall.
        gap_pct   = 0;
        stall_pct = 0;
        if (total <= 96) load_frame(total);
        hold_asks++;
        run_items(200, 95);
      end else begin
        if (total <= 96 && $urandom_range(9) < 8) load_frame(total);
        if ($urandom_range(9) == 0)
          run_items($urandom_range(20, 60), 20);
        else
          run_items($urandom_range(40, 100), 65);
      end
      phase++;
    end

    // Drain: no more items, no more stalls, wait for the last results.
    in_valid <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
